>>> sv/jsu_pkg.sv
// Shared types, codes and helper functions for the JSON string unescaper.
package jsu_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_BUSY   = 3'd0,
        ST_DONE   = 3'd1,
        ST_MISSQ  = 3'd2,
        ST_BADESC = 3'd3,
        ST_BADHEX = 3'd4,
        ST_BADSUR = 3'd5,
        ST_CTRL   = 3'd6
    } status_t;

    // Decoder phase, one-hot
    typedef enum logic [5:0] {
        PH_NORMAL   = 6'b000001,
        PH_ESC      = 6'b000010,
        PH_HEX1     = 6'b000100,
        PH_WANT_BSL = 6'b001000,
        PH_WANT_U   = 6'b010000,
        PH_HEX2     = 6'b100000
    } phase_t;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Surrogate bounds
    localparam logic [15:0] HI_SUR_MIN = 16'hD800;
    localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    // Decoder state carried between items
    typedef struct packed {
        phase_t      phase;
        logic [1:0]  digits;   // hex digits already seen in the current unit
        logic [11:0] accum;    // first three hex digits of a unit
        logic [9:0]  high;     // payload bits of a stored high surrogate
    } dec_state_t;

    // All result items caused by one input item
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            valid;
        status_t         status;
    } bundle_t;

    // Decode one hex digit: {bad, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b10000;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // Encode a code point as one to four UTF-8 bytes
    function automatic bundle_t utf8_encode(input logic [20:0] u);
        bundle_t b;
        b = '0;
        b.valid  = 1'b1;
        b.status = ST_BUSY;
        if (u <= 21'h7F) begin
            b.bytes[0] = u[7:0];
            b.last_idx = 2'd0;
        end else if (u <= 21'h7FF) begin
            b.bytes[0] = {3'b110, u[10:6]};
            b.bytes[1] = {2'b10, u[5:0]};
            b.last_idx = 2'd1;
        end else if (u <= 21'hFFFF) begin
            b.bytes[0] = {4'b1110, u[15:12]};
            b.bytes[1] = {2'b10, u[11:6]};
            b.bytes[2] = {2'b10, u[5:0]};
            b.last_idx = 2'd2;
        end else begin
            b.bytes[0] = {5'b11110, u[20:18]};
            b.bytes[1] = {2'b10, u[17:12]};
            b.bytes[2] = {2'b10, u[11:6]};
            b.bytes[3] = {2'b10, u[5:0]};
            b.last_idx = 2'd3;
        end
        return b;
    endfunction

endpackage

>>> sv/jsu_decode.sv
// Per-byte decode: next decoder state and the result bundle for one input byte.
module jsu_decode (
    input  logic [7:0]          in_byte,
    input  jsu_pkg::dec_state_t state_in,
    output jsu_pkg::dec_state_t state_out,
    output jsu_pkg::bundle_t    bundle
);

    jsu_pkg::dec_state_t idle_state;
    jsu_pkg::bundle_t    consumed;
    logic [4:0]          hd;
    logic [15:0]         unit;

    // Shared pieces
    always_comb begin
        idle_state        = '0;
        idle_state.phase  = jsu_pkg::PH_NORMAL;
        consumed          = '0;
        consumed.status   = jsu_pkg::ST_BUSY;
        hd                = jsu_pkg::hex_digit(in_byte);
        unit              = {state_in.accum, hd[3:0]};
    end

    // Decode by phase
    always_comb begin
        state_out = state_in;
        bundle    = consumed;
        case (state_in.phase)
            jsu_pkg::PH_ESC: begin
                state_out = idle_state;
                bundle.valid = 1'b1;
                case (in_byte)
                    jsu_pkg::CH_QUOTE: bundle.bytes[0] = jsu_pkg::CH_QUOTE;
                    jsu_pkg::CH_BSL:   bundle.bytes[0] = jsu_pkg::CH_BSL;
                    jsu_pkg::CH_SLASH: bundle.bytes[0] = jsu_pkg::CH_SLASH;
                    jsu_pkg::CH_B:     bundle.bytes[0] = 8'h08;
                    jsu_pkg::CH_F:     bundle.bytes[0] = 8'h0C;
                    jsu_pkg::CH_N:     bundle.bytes[0] = 8'h0A;
                    jsu_pkg::CH_R:     bundle.bytes[0] = 8'h0D;
                    jsu_pkg::CH_T:     bundle.bytes[0] = 8'h09;
                    jsu_pkg::CH_U: begin
                        bundle          = consumed;
                        state_out.phase = jsu_pkg::PH_HEX1;
                        state_out.accum = '0;
                    end
                    default: begin
                        bundle        = consumed;
                        bundle.status = jsu_pkg::ST_BADESC;
                    end
                endcase
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                if (hd[4]) begin
                    // not a hex digit
                    state_out     = idle_state;
                    bundle.status = jsu_pkg::ST_BADHEX;
                end else if (state_in.digits != 2'd3) begin
                    // gather one more digit
                    state_out.digits = state_in.digits + 2'd1;
                    state_out.accum  = unit[11:0];
                end else if (state_in.phase == jsu_pkg::PH_HEX1) begin
                    if (unit >= jsu_pkg::HI_SUR_MIN && unit <= jsu_pkg::HI_SUR_MAX) begin
                        // hold the high surrogate, wait for the low one
                        state_out       = idle_state;
                        state_out.phase = jsu_pkg::PH_WANT_BSL;
                        state_out.high  = unit[9:0];
                    end else begin
                        state_out = idle_state;
                        bundle    = jsu_pkg::utf8_encode({5'd0, unit});
                    end
                end else begin
                    state_out = idle_state;
                    if (unit < jsu_pkg::LO_SUR_MIN || unit > jsu_pkg::LO_SUR_MAX) begin
                        bundle.status = jsu_pkg::ST_BADSUR;
                    end else begin
                        bundle = jsu_pkg::utf8_encode(
                            {1'b0, state_in.high, unit[9:0]} + jsu_pkg::SUPP_BASE);
                    end
                end
            end
            jsu_pkg::PH_WANT_BSL: begin
                if (in_byte != jsu_pkg::CH_BSL) begin
                    state_out     = idle_state;
                    bundle.status = jsu_pkg::ST_BADSUR;
                end else begin
                    state_out.phase = jsu_pkg::PH_WANT_U;
                end
            end
            jsu_pkg::PH_WANT_U: begin
                if (in_byte != jsu_pkg::CH_U) begin
                    state_out     = idle_state;
                    bundle.status = jsu_pkg::ST_BADSUR;
                end else begin
                    state_out.phase  = jsu_pkg::PH_HEX2;
                    state_out.digits = 2'd0;
                    state_out.accum  = '0;
                end
            end
            default: begin
                // normal characters
                state_out = idle_state;
                if (in_byte == jsu_pkg::CH_QUOTE) begin
                    bundle.status = jsu_pkg::ST_DONE;
                end else if (in_byte == jsu_pkg::CH_NUL) begin
                    bundle.status = jsu_pkg::ST_MISSQ;
                end else if (in_byte == jsu_pkg::CH_BSL) begin
                    state_out.phase = jsu_pkg::PH_ESC;
                end else if (in_byte < jsu_pkg::CH_SPACE) begin
                    bundle.status = jsu_pkg::ST_CTRL;
                end else begin
                    bundle.valid    = 1'b1;
                    bundle.bytes[0] = in_byte;
                end
            end
        endcase
    end

endmodule

>>> sv/json_string_unescape_utf8_unit.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
// Input channel (s_): one raw byte of a JSON string body per item, the
// opening quote already stripped. A zero byte marks end of text.
// Result channel (m_): one output byte per item. m_tuser[0] flags a decoded
// byte, m_tuser[3:1] gives the status (busy, done or an error code), and
// m_tlast marks the final result item caused by one input byte. Every input
// byte gives at least one result item; a decoded character gives one to
// four, a consumed escape byte, a done or an error gives one with flag low.
// Latency: the first result of a byte appears on the cycle after it is
// accepted. Throughput: one input byte per cycle while each gives one result
// and no stall; a byte with several results holds the output register,
// which sends one byte per cycle while m_tready is high. The next input byte
// is taken in the same cycle as the last result of the previous one leaves.
// Reset empties the output register and returns the decoder to normal
// characters. When the receiver stalls, the current result item holds and
// s_tready drops until its last result item is taken.
module json_string_unescape_utf8_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [3:0] m_tuser,   // [0] out_valid, [3:1] status
    output logic       m_tlast
);

    jsu_pkg::dec_state_t state_reg, state_next;
    jsu_pkg::bundle_t    bundle_reg, bundle_next;
    jsu_pkg::bundle_t    dec_bundle;
    logic                bvalid_reg, bvalid_next;
    logic [1:0]          idx_reg, idx_next;
    logic                accept, take, drain_end;

    jsu_decode u_decode (
        .in_byte   (s_tdata),
        .state_in  (state_reg),
        .state_out (state_next),
        .bundle    (dec_bundle)
    );

    // Handshake
    assign take      = m_tvalid && m_tready;
    assign drain_end = take && (idx_reg == bundle_reg.last_idx);
    assign s_tready  = !bvalid_reg || drain_end;
    assign accept    = s_tvalid && s_tready;

    // Output register and byte index
    always_comb begin
        bundle_next = bundle_reg;
        bvalid_next = bvalid_reg;
        idx_next    = idx_reg;
        if (accept) begin
            bundle_next = dec_bundle;
            bvalid_next = 1'b1;
            idx_next    = 2'd0;
        end else if (drain_end) begin
            bvalid_next = 1'b0;
            idx_next    = 2'd0;
        end else if (take) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    // Control and decoder state; advance the decoder on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bvalid_reg <= 1'b0;
            idx_reg    <= 2'd0;
            state_reg  <= '{phase: jsu_pkg::PH_NORMAL, digits: 2'd0,
                            accum: 12'd0, high: 10'd0};
        end else begin
            bvalid_reg <= bvalid_next;
            idx_reg    <= idx_next;
            if (accept) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload register
    always_ff @(posedge aclk) begin
        bundle_reg <= bundle_next;
    end

    // Drive the result channel
    assign m_tvalid = bvalid_reg;
    assign m_tdata  = bundle_reg.bytes[idx_reg];
    assign m_tuser  = {bundle_reg.status, bundle_reg.valid};
    assign m_tlast  = (idx_reg == bundle_reg.last_idx);

`ifndef SYNTHESIS
    // A status other than busy never carries a decoded byte
    a_status_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[3:1] != jsu_pkg::ST_BUSY)) |-> !m_tuser[0])
        else $error("status item carries a decoded byte");

    // Only decoded characters span more than one result item
    a_multi_is_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> m_tuser[0])
        else $error("multi-item result without decoded byte");

    // An accepted item shows a result on the next cycle
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_tvalid && idx_reg == 2'd0))
        else $error("accepted item produced no result");

    // The byte index never runs past the last byte of the bundle
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (idx_reg <= bundle_reg.last_idx))
        else $error("byte index past end of bundle");

    // A stalled multi-byte result advances only on a take
    a_idx_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(idx_reg))
        else $error("byte index moved while stalled");
`endif

endmodule

>>> tb/tb_json_string_unescape_utf8_unit.sv
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module tb_json_string_unescape_utf8_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Digit and letter bounds for hex parsing
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;

    // Bytes produced by the single-letter escapes
    localparam logic [7:0] OUT_BS  = 8'h08;
    localparam logic [7:0] OUT_FF  = 8'h0C;
    localparam logic [7:0] OUT_LF  = 8'h0A;
    localparam logic [7:0] OUT_CR  = 8'h0D;
    localparam logic [7:0] OUT_TAB = 8'h09;

    localparam int DIRECTED_ITEMS = 26;
    localparam int RANDOM_ITEMS   = 404;
    localparam int CALM_FROM      = 400;
    localparam int CALM_TO        = 650;

    // Decoder phase of the predictor
    typedef enum logic [2:0] {
        DEC_TEXT,
        DEC_ESCAPE,
        DEC_UNIT1,
        DEC_NEED_BSL,
        DEC_NEED_U,
        DEC_UNIT2
    } dec_mode_t;

    typedef struct packed {
        logic [7:0]       data;
        logic             flag;
        jsu_pkg::status_t status;
        logic             last;
    } decoded_item_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [3:0] m_tuser;
    logic       m_tlast;

    logic [7:0]    pending_bytes[$];
    decoded_item_t expected_items[$];
    int            mismatches = 0;
    int unsigned   cyc = 0;
    logic          calm;

    // Predictor state
    dec_mode_t   dec_mode    = DEC_TEXT;
    logic [1:0]  unit_digits = 2'd0;
    logic [15:0] unit_acc    = 16'h0000;
    logic [15:0] high_unit   = 16'h0000;

    json_string_unescape_utf8_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
    end

    assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    // Hex digit value, or -1 for a byte that is not a hex digit
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    function automatic void post(input logic [7:0] d, input logic f,
                                 input jsu_pkg::status_t st, input logic l);
        decoded_item_t it;
        it.data   = d;
        it.flag   = f;
        it.status = st;
        it.last   = l;
        expected_items.push_back(it);
    endfunction

    function automatic void clear_decoder();
        dec_mode    = DEC_TEXT;
        unit_digits = 2'd0;
        unit_acc    = 16'h0000;
        high_unit   = 16'h0000;
    endfunction

    // End the string with a done or error status
    function automatic void close_string(input jsu_pkg::status_t st);
        clear_decoder();
        post(8'h00, 1'b0, st, 1'b1);
    endfunction

    function automatic void swallow();
        post(8'h00, 1'b0, jsu_pkg::ST_BUSY, 1'b1);
    endfunction

    // Emit a code point as one to four UTF-8 bytes
    function automatic void emit_utf8(input logic [20:0] cp);
        clear_decoder();
        if (cp <= 21'h7F) begin
            post(cp[7:0], 1'b1, jsu_pkg::ST_BUSY, 1'b1);
        end else if (cp <= 21'h7FF) begin
            post(8'hC0 | {3'b000, cp[10:6]}, 1'b1, jsu_pkg::ST_BUSY, 1'b0);
            post(8'h80 | {2'b00, cp[5:0]}, 1'b1, jsu_pkg::ST_BUSY, 1'b1);
        end else if (cp <= 21'hFFFF) begin
            post(8'hE0 | {4'h0, cp[15:12]}, 1'b1, jsu_pkg::ST_BUSY, 1'b0);
            post(8'h80 | {2'b00, cp[11:6]}, 1'b1, jsu_pkg::ST_BUSY, 1'b0);
            post(8'h80 | {2'b00, cp[5:0]}, 1'b1, jsu_pkg::ST_BUSY, 1'b1);
        end else begin
            post(8'hF0 | {5'b00000, cp[20:18]}, 1'b1, jsu_pkg::ST_BUSY, 1'b0);
            post(8'h80 | {2'b00, cp[17:12]}, 1'b1, jsu_pkg::ST_BUSY, 1'b0);
            post(8'h80 | {2'b00, cp[11:6]}, 1'b1, jsu_pkg::ST_BUSY, 1'b0);
            post(8'h80 | {2'b00, cp[5:0]}, 1'b1, jsu_pkg::ST_BUSY, 1'b1);
        end
    endfunction

    // Advance the predictor by one accepted input byte
    function automatic void decode_byte(input logic [7:0] c);
        int nib;
        logic [20:0] cp;
        case (dec_mode)
            DEC_ESCAPE: begin
                dec_mode = DEC_TEXT;
                case (c)
                    jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH:
                        post(c, 1'b1, jsu_pkg::ST_BUSY, 1'b1);
                    jsu_pkg::CH_B: post(OUT_BS, 1'b1, jsu_pkg::ST_BUSY, 1'b1);
                    jsu_pkg::CH_F: post(OUT_FF, 1'b1, jsu_pkg::ST_BUSY, 1'b1);
                    jsu_pkg::CH_N: post(OUT_LF, 1'b1, jsu_pkg::ST_BUSY, 1'b1);
                    jsu_pkg::CH_R: post(OUT_CR, 1'b1, jsu_pkg::ST_BUSY, 1'b1);
                    jsu_pkg::CH_T: post(OUT_TAB, 1'b1, jsu_pkg::ST_BUSY, 1'b1);
                    jsu_pkg::CH_U: begin
                        dec_mode    = DEC_UNIT1;
                        unit_digits = 2'd0;
                        unit_acc    = 16'h0000;
                        swallow();
                    end
                    default: close_string(jsu_pkg::ST_BADESC);
                endcase
            end
            DEC_UNIT1, DEC_UNIT2: begin
                nib = hex_nibble(c);
                if (nib < 0) begin
                    close_string(jsu_pkg::ST_BADHEX);
                end else begin
                    unit_acc = {unit_acc[11:0], 4'(nib)};
                    if (unit_digits != 2'd3) begin
                        unit_digits = unit_digits + 2'd1;
                        swallow();
                    end else if (dec_mode == DEC_UNIT1) begin
                        if (unit_acc >= jsu_pkg::HI_SUR_MIN
                                && unit_acc <= jsu_pkg::HI_SUR_MAX) begin
                            // hold the high half, wait for the low one
                            high_unit   = unit_acc;
                            unit_acc    = 16'h0000;
                            unit_digits = 2'd0;
                            dec_mode    = DEC_NEED_BSL;
                            swallow();
                        end else begin
                            emit_utf8({5'b00000, unit_acc});
                        end
                    end else if (unit_acc < jsu_pkg::LO_SUR_MIN
                                 || unit_acc > jsu_pkg::LO_SUR_MAX) begin
                        close_string(jsu_pkg::ST_BADSUR);
                    end else begin
                        cp = ((21'(high_unit - jsu_pkg::HI_SUR_MIN) & 21'h3FF) << 10)
                             | 21'(unit_acc - jsu_pkg::LO_SUR_MIN);
                        emit_utf8(cp + jsu_pkg::SUPP_BASE);
                    end
                end
            end
            DEC_NEED_BSL: begin
                if (c != jsu_pkg::CH_BSL) begin
                    close_string(jsu_pkg::ST_BADSUR);
                end else begin
                    dec_mode = DEC_NEED_U;
                    swallow();
                end
            end
            DEC_NEED_U: begin
                if (c != jsu_pkg::CH_U) begin
                    close_string(jsu_pkg::ST_BADSUR);
                end else begin
                    dec_mode    = DEC_UNIT2;
                    unit_digits = 2'd0;
                    unit_acc    = 16'h0000;
                    swallow();
                end
            end
            default: begin
                if (c == jsu_pkg::CH_QUOTE) begin
                    close_string(jsu_pkg::ST_DONE);
                end else if (c == jsu_pkg::CH_NUL) begin
                    close_string(jsu_pkg::ST_MISSQ);
                end else if (c == jsu_pkg::CH_BSL) begin
                    dec_mode = DEC_ESCAPE;
                    swallow();
                end else if (c < jsu_pkg::CH_SPACE) begin
                    close_string(jsu_pkg::ST_CTRL);
                end else begin
                    post(c, 1'b1, jsu_pkg::ST_BUSY, 1'b1);
                end
            end
        endcase
    endfunction

    // Stimulus helpers
    function automatic logic [7:0] escape_letter(input int i);
        case (i)
            0: return jsu_pkg::CH_QUOTE;
            1: return jsu_pkg::CH_BSL;
            2: return jsu_pkg::CH_SLASH;
            3: return jsu_pkg::CH_B;
            4: return jsu_pkg::CH_F;
            5: return jsu_pkg::CH_N;
            6: return jsu_pkg::CH_R;
            default: return jsu_pkg::CH_T;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return CH_0 + {4'h0, n};
        return ($urandom_range(1) ? CH_LA : CH_UA) + {4'h0, n - 4'd10};
    endfunction

    function automatic void queue_unit(input logic [15:0] u);
        pending_bytes.push_back(jsu_pkg::CH_BSL);
        pending_bytes.push_back(jsu_pkg::CH_U);
        for (int i = 3; i >= 0; i--) begin
            pending_bytes.push_back(hex_char(u[4*i +: 4]));
        end
    endfunction

    function automatic logic [15:0] high_half();
        return jsu_pkg::HI_SUR_MIN + 16'($urandom_range(0, 'h3FF));
    endfunction

    // A single unit that never opens a surrogate pair
    function automatic logic [15:0] plain_unit();
        logic [15:0] u;
        case ($urandom_range(4))
            0: u = 16'($urandom_range(0, 'h7F));
            1: u = 16'($urandom_range('h80, 'h7FF));
            2: u = ($urandom_range(1)) ? 16'h0000 : 16'hFFFF;
            3: u = jsu_pkg::LO_SUR_MIN + 16'($urandom_range(0, 'h3FF));
            default: begin
                do u = 16'($urandom_range('h800, 'hFFFF));
                while (u >= jsu_pkg::HI_SUR_MIN && u <= jsu_pkg::HI_SUR_MAX);
            end
        endcase
        return u;
    endfunction

    // Driver: present queued bytes with random gaps; predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_bytes.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 34);
        end
    end

    // Monitor: compare each result item with the oldest expectation
    always @(posedge aclk) begin
        decoded_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_items.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) begin
                    $display("unexpected item: byte=%h flag=%b status=%0d last=%b",
                             m_tdata, m_tuser[0], m_tuser[3:1], m_tlast);
                end
            end else begin
                want = expected_items.pop_front();
                if (m_tdata !== want.data || m_tuser[0] !== want.flag
                        || m_tuser[3:1] !== want.status || m_tlast !== want.last) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("mismatch: want byte=%h flag=%b status=%0d last=%b",
                                 want.data, want.flag, want.status, want.last);
                        $display("          got  byte=%h flag=%b status=%0d last=%b",
                                 m_tdata, m_tuser[0], m_tuser[3:1], m_tlast);
                    end
                end
            end
        end
    end

    // Fill the stimulus queue, run reset, wait for the drain
    initial begin
        int pick;
        int target;
        bit broken;
        logic [7:0] b;
        logic [15:0] u;

        // Directed: escape, edge bytes, 3-byte and 4-byte sequences, end codes
        pending_bytes.push_back(jsu_pkg::CH_BSL);
        pending_bytes.push_back(jsu_pkg::CH_N);
        pending_bytes.push_back(jsu_pkg::CH_SPACE);
        pending_bytes.push_back(8'h7F);
        pending_bytes.push_back(8'hFF);
        queue_unit(16'h20AC);
        queue_unit(16'hD83D);
        queue_unit(16'hDE00);
        pending_bytes.push_back(jsu_pkg::CH_QUOTE);
        pending_bytes.push_back(8'h01);
        pending_bytes.push_back(jsu_pkg::CH_NUL);

        target = DIRECTED_ITEMS + RANDOM_ITEMS;
        while (pending_bytes.size() < target) begin
            broken = 1'b0;
            if ($urandom_range(99) < 6) begin
                // raw noise bytes
                repeat ($urandom_range(1, 6)) pending_bytes.push_back(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    if (!broken) begin
                        pick = $urandom_range(99);
                        if (pick < 35) begin
                            do b = 8'($urandom_range('h20, 'hFF));
                            while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSL);
                            pending_bytes.push_back(b);
                        end else if (pick < 50) begin
                            pending_bytes.push_back(jsu_pkg::CH_BSL);
                            pending_bytes.push_back(escape_letter($urandom_range(7)));
                        end else if (pick < 68) begin
                            queue_unit(plain_unit());
                        end else if (pick < 82) begin
                            queue_unit(high_half());
                            queue_unit(jsu_pkg::LO_SUR_MIN + 16'($urandom_range(0, 'h3FF)));
                        end else begin
                            broken = 1'b1;
                            case ($urandom_range(5))
                                0: begin
                                    // unknown escape letter, zero included
                                    pending_bytes.push_back(jsu_pkg::CH_BSL);
                                    if ($urandom_range(3) == 0) begin
                                        b = jsu_pkg::CH_NUL;
                                    end else begin
                                        do b = 8'($urandom);
                                        while (b == jsu_pkg::CH_U || b == jsu_pkg::CH_QUOTE
                                               || b == jsu_pkg::CH_BSL
                                               || b == jsu_pkg::CH_SLASH
                                               || b == jsu_pkg::CH_B || b == jsu_pkg::CH_F
                                               || b == jsu_pkg::CH_N || b == jsu_pkg::CH_R
                                               || b == jsu_pkg::CH_T);
                                    end
                                    pending_bytes.push_back(b);
                                end
                                1: begin
                                    // non-hex byte inside a unit
                                    if ($urandom_range(1)) begin
                                        queue_unit(high_half());
                                    end
                                    pending_bytes.push_back(jsu_pkg::CH_BSL);
                                    pending_bytes.push_back(jsu_pkg::CH_U);
                                    repeat ($urandom_range(0, 3)) begin
                                        pending_bytes.push_back(hex_char(4'($urandom)));
                                    end
                                    do b = 8'($urandom);
                                    while (hex_nibble(b) >= 0);
                                    pending_bytes.push_back(b);
                                end
                                2: begin
                                    // high half not followed by a backslash
                                    queue_unit(high_half());
                                    do b = 8'($urandom);
                                    while (b == jsu_pkg::CH_BSL);
                                    pending_bytes.push_back(b);
                                end
                                3: begin
                                    // backslash but no 'u' after a high half
                                    queue_unit(high_half());
                                    pending_bytes.push_back(jsu_pkg::CH_BSL);
                                    do b = 8'($urandom);
                                    while (b == jsu_pkg::CH_U);
                                    pending_bytes.push_back(b);
                                end
                                4: begin
                                    // second unit outside the low range
                                    queue_unit(high_half());
                                    do u = 16'($urandom);
                                    while (u >= jsu_pkg::LO_SUR_MIN
                                           && u <= jsu_pkg::LO_SUR_MAX);
                                    queue_unit(u);
                                end
                                default: begin
                                    pending_bytes.push_back(8'($urandom_range(1, 'h1F)));
                                end
                            endcase
                        end
                    end
                end
            end
            // close the string unless an error already did
            if (!broken) begin
                pending_bytes.push_back(($urandom_range(9) == 0) ? jsu_pkg::CH_NUL
                                                                 : jsu_pkg::CH_QUOTE);
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: all sent, all results back, then a short hold-off
        @(negedge aclk);
        while (pending_bytes.size() != 0 || s_tvalid || expected_items.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_items.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #200000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
sv/jsu_pkg.sv
sv/jsu_decode.sv
sv/json_string_unescape_utf8_unit.sv
tb/tb_json_string_unescape_utf8_unit.sv
